>>> rtl/contact_process_event_step_assert.svh
// Assertion macros for the checker file of the contact process block.
`ifndef CONTACT_PROCESS_EVENT_STEP_ASSERT_SVH
`define CONTACT_PROCESS_EVENT_STEP_ASSERT_SVH

// Concurrent check on the rising clock, switched off while reset is held.
`define CPES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent check on the rising clock that also covers the reset period.
`define CPES_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/cpes_pkg.sv
// Package with the types, codes and constants of the contact process block.
package cpes_pkg;

    localparam int MAX_SITES  = 1024;
    localparam int SITE_W     = 10;
    localparam int CNT_W      = 11;
    localparam int NSUM_W     = 12;
    localparam int HIR_W      = 20;
    localparam int RING_W     = 11;
    localparam int TIME_W     = 48;
    localparam int W_W        = 32;
    localparam int X_W        = 32;
    localparam int E_W        = 32;
    localparam int SWORD_W    = 3;
    localparam int SUM_W      = 34;
    localparam int DIVIDEND_W = E_W + 8;
    localparam int IN_DATA_W  = 80;
    localparam int USER_W     = 2;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_DATA_W = 20;

    localparam logic [HIR_W-1:0]  HIR_RESET  = 20'd32768;
    localparam logic [RING_W-1:0] RING_RESET = 11'd1024;
    localparam logic [RING_W-1:0] RING_MIN   = 11'd3;
    localparam logic [RING_W-1:0] RING_MAX   = RING_W'(MAX_SITES);
    localparam logic [SUM_W-1:0]  ONE_Q16    = 34'd65536;

    typedef enum logic [1:0] {
        OP_SET_ACTIVE   = 2'd0,
        OP_SET_INACTIVE = 2'd1,
        OP_STEP         = 2'd2,
        OP_CLEAR        = 2'd3
    } cpes_op_t;

    typedef enum logic {
        REG_HALF_RATE = 1'b0,
        REG_RING_SIZE = 1'b1
    } cpes_reg_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_MUL1, ST_MUL2, ST_W_LIST, ST_W_SITE,
        ST_W_ACC, ST_DIV_START, ST_DIV_WAIT, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
        ST_CHECK, ST_COUNT, ST_WR, ST_PUSH, ST_ER_SEL, ST_ER_RD, ST_ER_CMP,
        ST_SH_RD, ST_SH_WR, ST_FIN
    } cpes_state_t;

    typedef struct packed {
        logic       in_ready;
        logic       clr_start;
        logic       clr_step;
        logic       cap_site;
        logic [1:0] cap_slot;
        logic [1:0] slot;
        logic       upd_count;
        logic       set_flip;
        logic       wr_site;
        logic       push;
        logic       find_start;
        logic       find_next;
        logic       list_rd_nxt;
        logic       shift_wr;
        logic       dec_total;
        logic       mul1;
        logic       mul2;
        logic       walk_rd_site;
        logic       walk_acc;
        logic       div_start;
        logic       time_upd;
        logic       load_out;
    } cpes_cmd_t;

    typedef struct packed {
        cpes_op_t   op;
        logic       in_range;
        logic       step_ok;
        logic       flip_ok;
        logic       act;
        logic       clr_last;
        logic [2:0] need_push;
        logic [2:0] need_erase;
        logic       list_match;
        logic       k_last;
        logic       walk_hit;
        logic       div_busy;
        logic       out_free;
    } cpes_status_t;

endpackage

>>> rtl/cpes_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cpes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cpes_div.sv
// Restoring divider that produces one quotient bit per cycle.
module cpes_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cpes_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [cpes_pkg::W_W-1:0]        divisor,
    output logic                           busy,
    output logic [cpes_pkg::DIVIDEND_W-1:0] quotient
);
    import cpes_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [W_W-1:0]        rem_reg;
    logic [W_W-1:0]        dvs_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [W_W:0]          shifted;
    logic [W_W:0]          diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CNT_BITS'(DIVIDEND_W - 1);
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= ge ? diff[W_W-1:0] : shifted[W_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/cpes_ctrl.sv
// Controller state machine that sequences every item through the datapath.
module cpes_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   cfg_ring_wr,
    input  cpes_pkg::cpes_status_t status,
    output cpes_pkg::cpes_cmd_t    cmd
);
    import cpes_pkg::*;

    cpes_state_t state_reg, state_next;
    logic [1:0]  p_reg, p_next;
    logic        clr_item_reg, clr_item_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            p_reg        <= 2'd0;
            clr_item_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p_reg        <= p_next;
            clr_item_reg <= clr_item_next;
        end
    end

    // Next state.
    always_comb begin
        state_next    = state_reg;
        p_next        = p_reg;
        clr_item_next = clr_item_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = clr_item_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cfg_ring_wr) begin
                    state_next    = ST_CLEAR;
                    clr_item_next = 1'b0;
                end else if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.op)
                    OP_CLEAR: begin
                        state_next    = ST_CLEAR;
                        clr_item_next = 1'b1;
                    end
                    OP_STEP: state_next = status.step_ok ? ST_MUL1 : ST_FIN;
                    default: state_next = status.in_range ? ST_RD0 : ST_FIN;
                endcase
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_W_LIST;
            ST_W_LIST: state_next = ST_W_SITE;
            ST_W_SITE: state_next = ST_W_ACC;
            ST_W_ACC: begin
                if (status.walk_hit) begin
                    state_next = ST_DIV_START;
                end else if (status.k_last) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_W_SITE;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_CHECK;
            ST_CHECK: state_next = status.flip_ok ? ST_COUNT : ST_FIN;
            ST_COUNT: begin
                state_next = ST_WR;
                p_next     = 2'd0;
            end
            ST_WR: begin
                if (p_reg == 2'd2) begin
                    p_next     = 2'd0;
                    state_next = status.act ? ST_PUSH : ST_ER_SEL;
                end else begin
                    p_next = p_reg + 2'd1;
                end
            end
            ST_PUSH: begin
                if (p_reg == 2'd2) begin
                    state_next = ST_FIN;
                end else begin
                    p_next = p_reg + 2'd1;
                end
            end
            ST_ER_SEL: begin
                if (status.need_erase[p_reg]) begin
                    state_next = ST_ER_RD;
                end else if (p_reg == 2'd2) begin
                    state_next = ST_FIN;
                end else begin
                    p_next = p_reg + 2'd1;
                end
            end
            ST_ER_RD: state_next = ST_ER_CMP;
            ST_ER_CMP: begin
                if (status.list_match) begin
                    state_next = ST_SH_RD;
                end else if (status.k_last) begin
                    state_next = (p_reg == 2'd2) ? ST_FIN : ST_ER_SEL;
                    p_next     = (p_reg == 2'd2) ? p_reg : p_reg + 2'd1;
                end else begin
                    state_next = ST_ER_RD;
                end
            end
            ST_SH_RD: begin
                if (status.k_last) begin
                    state_next = (p_reg == 2'd2) ? ST_FIN : ST_ER_SEL;
                    p_next     = (p_reg == 2'd2) ? p_reg : p_reg + 2'd1;
                end else begin
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR: state_next = ST_SH_RD;
            ST_FIN: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd      = '0;
        cmd.slot = p_reg;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                cmd.in_ready  = !cfg_ring_wr;
                cmd.clr_start = cfg_ring_wr;
            end
            ST_DECODE: cmd.clr_start = (status.op == OP_CLEAR);
            ST_MUL1:   cmd.mul1 = 1'b1;
            ST_MUL2:   cmd.mul2 = 1'b1;
            ST_W_SITE: cmd.walk_rd_site = 1'b1;
            ST_W_ACC: begin
                cmd.walk_acc    = 1'b1;
                cmd.list_rd_nxt = 1'b1;
            end
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd.time_upd  = !status.div_busy;
            ST_RD0: cmd.slot = 2'd0;
            ST_RD1: begin
                cmd.cap_site = 1'b1;
                cmd.cap_slot = 2'd0;
                cmd.slot     = 2'd1;
            end
            ST_RD2: begin
                cmd.cap_site = 1'b1;
                cmd.cap_slot = 2'd1;
                cmd.slot     = 2'd2;
            end
            ST_RD3: begin
                cmd.cap_site = 1'b1;
                cmd.cap_slot = 2'd2;
            end
            ST_COUNT: begin
                cmd.upd_count = 1'b1;
                cmd.set_flip  = 1'b1;
            end
            ST_WR: cmd.wr_site = 1'b1;
            ST_PUSH: begin
                // Appends go left neighbour, right neighbour, then the site.
                cmd.push = 1'b1;
                cmd.slot = (p_reg == 2'd2) ? 2'd0 : p_reg + 2'd1;
            end
            ST_ER_SEL: cmd.find_start = status.need_erase[p_reg];
            ST_ER_CMP: cmd.find_next  = !status.list_match && !status.k_last;
            ST_SH_RD: begin
                cmd.dec_total   = status.k_last;
                cmd.list_rd_nxt = !status.k_last;
            end
            ST_SH_WR: cmd.shift_wr = 1'b1;
            ST_FIN:   cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

>>> rtl/cpes_dp.sv
// Datapath: site and list memories, counts, rate walk, divider and result register.
module cpes_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cpes_pkg::cpes_cmd_t            cmd,
    output cpes_pkg::cpes_status_t         status,
    input  logic                           s_tvalid,
    input  logic [cpes_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [cpes_pkg::USER_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cpes_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [cpes_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cpes_pkg::*;

    logic [HIR_W-1:0]      hir_reg;
    logic [RING_W-1:0]     ring_reg;
    logic [RING_W-1:0]     ring_wr;
    cpes_op_t              op_reg;
    logic [SITE_W-1:0]     tgt_reg;
    logic [SITE_W-1:0]     s_reg;
    logic [X_W-1:0]        x_reg;
    logic [E_W-1:0]        e_reg;
    logic [2:0]            sbit_reg;
    logic [2:0][1:0]       snbr_reg;
    logic [CNT_W-1:0]      total_reg;
    logic [CNT_W-1:0]      active_reg;
    logic [NSUM_W-1:0]     nsum_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [W_W-1:0]        w_reg;
    logic [2*W_W-1:0]      prod_reg;
    logic [SUM_W-1:0]      thr_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [SITE_W-1:0]     clr_addr_reg;
    logic                  flip_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [SITE_W-1:0]  left_site, right_site, cur_site;
    logic               cur_bit;
    logic [1:0]         cur_nbr;
    logic [SWORD_W-1:0] new_word;
    logic               act;
    logic [CNT_W-1:0]   k_plus;
    logic [1:0]         inact_nbrs;
    logic [NSUM_W+HIR_W-1:0] nsum_prod;
    logic [W_W:0]       w_full;
    logic [2*W_W:0]     target;
    logic [SUM_W-1:0]   rate, sum_next;
    logic               walk_hit;
    logic [TIME_W:0]    t_sum;
    logic               div_busy;
    logic [DIVIDEND_W-1:0] dt;
    logic               in_fire;
    logic               push_en;

    logic               site_we;
    logic [SITE_W-1:0]  site_waddr, site_raddr;
    logic [SWORD_W-1:0] site_wdata, site_rdata;
    logic               list_we;
    logic [SITE_W-1:0]  list_waddr, list_raddr, list_wdata, list_rdata;

    // Ring neighbours of the target site.
    assign left_site  = (tgt_reg == '0) ? SITE_W'(ring_reg - 1'b1) : tgt_reg - 1'b1;
    assign right_site = ({1'b0, tgt_reg} + 1'b1 >= ring_reg) ? '0 : tgt_reg + 1'b1;

    always_comb begin
        case (cmd.slot)
            2'd1: begin
                cur_site = left_site;
                cur_bit  = sbit_reg[1];
                cur_nbr  = snbr_reg[1];
            end
            2'd2: begin
                cur_site = right_site;
                cur_bit  = sbit_reg[2];
                cur_nbr  = snbr_reg[2];
            end
            default: begin
                cur_site = tgt_reg;
                cur_bit  = sbit_reg[0];
                cur_nbr  = snbr_reg[0];
            end
        endcase
    end

    assign act = !sbit_reg[0];

    // The target takes the new state; a neighbour gains or loses one active neighbour.
    always_comb begin
        if (cmd.slot == 2'd0 || cmd.slot == 2'd3) begin
            new_word = {act, cur_nbr};
        end else begin
            new_word = {cur_bit, act ? cur_nbr + 2'd1 : cur_nbr - 2'd1};
        end
    end

    assign k_plus     = k_reg + 1'b1;
    assign inact_nbrs = {1'b0, !sbit_reg[1]} + {1'b0, !sbit_reg[2]};
    assign push_en    = cmd.push && status.need_push[cmd.slot];
    assign in_fire    = s_tvalid && cmd.in_ready;

    // Memories.
    assign site_we    = cmd.clr_step || cmd.wr_site;
    assign site_waddr = cmd.clr_step ? clr_addr_reg : cur_site;
    assign site_wdata = cmd.clr_step ? '0 : new_word;
    assign site_raddr = cmd.walk_rd_site ? list_rdata : cur_site;

    assign list_we    = push_en || cmd.shift_wr;
    assign list_waddr = push_en ? total_reg[SITE_W-1:0] : k_reg[SITE_W-1:0];
    assign list_wdata = push_en ? cur_site : list_rdata;
    assign list_raddr = cmd.list_rd_nxt ? k_plus[SITE_W-1:0] : k_reg[SITE_W-1:0];

    cpes_ram #(.WIDTH(SWORD_W), .DEPTH(MAX_SITES)) u_site_ram (
        .aclk  (aclk),
        .we    (site_we),
        .waddr (site_waddr),
        .wdata (site_wdata),
        .raddr (site_raddr),
        .rdata (site_rdata)
    );

    cpes_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_list_ram (
        .aclk  (aclk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // Rate walk arithmetic.
    assign target = {1'b0, prod_reg} + (2*W_W+1)'(w_reg);
    always_comb begin
        if (site_rdata[2]) begin
            rate = ONE_Q16;
        end else if (site_rdata[1]) begin
            rate = SUM_W'({hir_reg, 1'b0});
        end else if (site_rdata[0]) begin
            rate = SUM_W'(hir_reg);
        end else begin
            rate = '0;
        end
    end
    assign sum_next = sum_reg + rate;
    assign walk_hit = (sum_next[SUM_W-1:W_W] != '0) || (sum_next >= thr_reg);

    assign nsum_prod = nsum_reg * hir_reg;
    assign w_full    = (W_W+1)'({active_reg, 16'd0}) + (W_W+1)'(nsum_prod);

    cpes_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({e_reg, 8'd0}),
        .divisor  (w_reg),
        .busy     (div_busy),
        .quotient (dt)
    );

    assign t_sum = {1'b0, time_reg} + (TIME_W+1)'(dt);

    always_comb begin
        ring_wr = cfg_wdata[RING_W-1:0];
        if (ring_wr < RING_MIN) begin
            ring_wr = RING_MIN;
        end else if (ring_wr > RING_MAX) begin
            ring_wr = RING_MAX;
        end
    end

    // Configuration and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hir_reg      <= HIR_RESET;
            ring_reg     <= RING_RESET;
            total_reg    <= '0;
            active_reg   <= '0;
            nsum_reg     <= '0;
            time_reg     <= '0;
            w_reg        <= '0;
            clr_addr_reg <= '0;
            flip_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_HALF_RATE) begin
                hir_reg <= cfg_wdata[HIR_W-1:0];
            end
            if (cfg_we && cfg_index == REG_RING_SIZE) begin
                ring_reg <= ring_wr;
            end
            w_reg <= w_full[W_W] ? '1 : w_full[W_W-1:0];

            if (cmd.clr_start) begin
                clr_addr_reg <= '0;
                total_reg    <= '0;
                active_reg   <= '0;
                nsum_reg     <= '0;
                time_reg     <= '0;
            end else begin
                if (cmd.clr_step) begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                if (cmd.upd_count) begin
                    if (act) begin
                        active_reg <= active_reg + 1'b1;
                        nsum_reg   <= nsum_reg - NSUM_W'(snbr_reg[0]) + NSUM_W'(inact_nbrs);
                    end else begin
                        active_reg <= active_reg - 1'b1;
                        nsum_reg   <= nsum_reg + NSUM_W'(snbr_reg[0]) - NSUM_W'(inact_nbrs);
                    end
                end
                if (push_en) begin
                    total_reg <= total_reg + 1'b1;
                end else if (cmd.dec_total) begin
                    total_reg <= total_reg - 1'b1;
                end
                if (cmd.time_upd) begin
                    time_reg <= t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
                end
            end

            if (in_fire) begin
                flip_reg <= 1'b0;
            end else if (cmd.set_flip) begin
                flip_reg <= 1'b1;
            end

            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= cpes_op_t'(s_tuser);
            tgt_reg <= s_tdata[SITE_W-1:0];
            x_reg   <= s_tdata[SITE_W+X_W-1:SITE_W];
            e_reg   <= s_tdata[SITE_W+X_W+E_W-1:SITE_W+X_W];
        end else if (cmd.walk_acc && walk_hit) begin
            tgt_reg <= s_reg;
        end
        if (cmd.cap_site) begin
            sbit_reg[cmd.cap_slot] <= site_rdata[2];
            snbr_reg[cmd.cap_slot] <= site_rdata[1:0];
        end
        if (cmd.mul1) begin
            prod_reg <= x_reg * w_reg;
        end
        if (cmd.mul2) begin
            thr_reg <= SUM_W'(target[2*W_W:W_W]) + SUM_W'(|target[W_W-1:0]);
            sum_reg <= '0;
        end else if (cmd.walk_acc) begin
            sum_reg <= sum_next;
        end
        if (cmd.walk_rd_site) begin
            s_reg <= list_rdata;
        end
        if (cmd.mul2 || cmd.find_start) begin
            k_reg <= '0;
        end else if (cmd.find_next || cmd.shift_wr || (cmd.walk_acc && !walk_hit)) begin
            k_reg <= k_plus;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {total_reg == '0, time_reg, w_reg, total_reg,
                            flip_reg && act, flip_reg ? tgt_reg : '0, flip_reg};
        end
    end

    assign status.op         = op_reg;
    assign status.in_range   = {1'b0, tgt_reg} < ring_reg;
    assign status.step_ok    = (total_reg != '0) && (w_reg != '0);
    assign status.flip_ok    = (op_reg == OP_STEP) ||
                               (sbit_reg[0] != (op_reg == OP_SET_ACTIVE));
    assign status.act        = act;
    assign status.clr_last   = clr_addr_reg == SITE_W'(MAX_SITES - 1);
    assign status.need_push  = {!sbit_reg[2] && snbr_reg[2] == 2'd0,
                                !sbit_reg[1] && snbr_reg[1] == 2'd0,
                                snbr_reg[0] == 2'd0};
    assign status.need_erase = {!sbit_reg[2] && snbr_reg[2] == 2'd1,
                                !sbit_reg[1] && snbr_reg[1] == 2'd1,
                                snbr_reg[0] == 2'd0};
    assign status.list_match = list_rdata == cur_site;
    assign status.k_last     = k_plus == total_reg;
    assign status.walk_hit   = walk_hit;
    assign status.div_busy   = div_busy;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/contact_process_event_step.sv
// Top level of the one-dimensional contact process event stepper.
//
// Channel   Direction  Handshake            Contents
// s_        in         s_tvalid / s_tready  opcode in tuser, site and variates in tdata
// m_        out        m_tvalid / m_tready  one result transaction per input transaction
// cfg_      in         cfg_we               register index and write data, no read-back
//
// A set-active or set-inactive item reads and rewrites the site and its neighbours and,
// for each list entry that leaves the candidate list, searches for it and moves the rest.
// A step item walks the candidate entries (list memory, then site memory), waits on
// the serial divider (one quotient bit per cycle over 40 bits), and then flips the
// chosen site.
// A clear item, reset and a ring_size write while idle run a clearing pass over all 1024
// site-memory words while s_tready stays low.
// One item is processed at a time; a finished result waits in the output register
// while the next transaction is taken, and the next result cannot be loaded, so the
// input stays closed, until m_tready takes the waiting one.
module contact_process_event_step (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0: site[9:0], pick_fraction[41:10], wait_variate[73:42], zeros
    input  logic [cpes_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [cpes_pkg::USER_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: flipped[0], flipped_site[10:1], new_value[11],
    // candidate_count[22:12], total_rate[54:23], elapsed_time[102:55], extinct[103]
    output logic [cpes_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [cpes_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cpes_pkg::*;

    cpes_cmd_t    cmd;
    cpes_status_t status;
    logic         cfg_ring_wr;

    // A ring_size write in the idle state also empties the ring, so the controller starts a clearing pass.
    assign cfg_ring_wr = cfg_we && (cfg_index == REG_RING_SIZE);

    cpes_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .cfg_ring_wr (cfg_ring_wr),
        .status      (status),
        .cmd         (cmd)
    );

    cpes_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // The input side is open only while the controller waits for an item.
    assign s_tready = cmd.in_ready;

endmodule

>>> rtl/cpes_checker.sv
// Port-level checker for the contact process stepper, bound to the top level.
`include "contact_process_event_step_assert.svh"

module cpes_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [103:0]  m_tdata
);

    `CPES_ASSERT(a_extinct_count, m_tvalid |-> (m_tdata[103] == (m_tdata[22:12] == 11'd0)), "extinct disagrees with candidate_count")
    `CPES_ASSERT(a_noflip_zero, (m_tvalid && !m_tdata[0]) |-> (m_tdata[11:1] == 11'd0), "site or value set without a flip")
    `CPES_ASSERT(a_count_bound, m_tvalid |-> (m_tdata[22:12] <= 11'd1024), "candidate_count above ring capacity")
    `CPES_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `CPES_ASSERT_ALWAYS(a_clear_after_reset, !$past(aresetn) |-> !s_tready, "input accepted during clearing pass")

endmodule

bind contact_process_event_step cpes_checker u_cpes_checker (.*);
